@@ rtl/tbpl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpl_pkg
// types, constants and helpers shared by the three-band low-pass mixer
// ----------------------------------------------------------------------------
package tbpl_pkg;

  localparam int CHANNELS  = 16;
  localparam int BANDS     = 3;
  localparam int MEM_DEPTH = CHANNELS * BANDS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CFG_W     = 48;
  localparam int IDX_W     = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_BAND_ONE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_BAND_TWO   = 2'd1;
  localparam logic [IDX_W-1:0] REG_BAND_THREE = 2'd2;
  localparam logic [IDX_W-1:0] REG_MIX_SELECT = 2'd3;

  localparam logic [2:0] MIX_SELECT_RESET = 3'b111;

  typedef struct packed {
    logic [3:0]         channel;
    logic signed [23:0] sample_one;
    logic signed [23:0] sample_two;
    logic signed [23:0] sample_three;
    logic signed [23:0] link_sample;
  } in_t;

  typedef struct packed {
    logic [3:0]         channel_out;
    logic signed [23:0] filtered_one;
    logic signed [23:0] filtered_two;
    logic signed [23:0] filtered_three;
    logic signed [23:0] mix_out;
  } out_t;

  // add half then floor
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    else if (v < -64'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage

@@ rtl/three_band_one_pole_lowpass_mixer_unit.sv @@
// ----------------------------------------------------------------------------
// three_band_one_pole_lowpass_mixer_unit
// three trapezoidal one-pole low-pass filters per channel, gained and mixed
// ----------------------------------------------------------------------------
//  channel  | ports                                   | transaction
//  ---------+-----------------------------------------+---------------------------
//  input    | in_valid / in_ready / in_data           | channel, three bands, link
//  result   | out_valid / out_ready / out_data        | three filtered bands, mix
//  config   | cfg_we / cfg_index / cfg_data           | one register write
//
//  one transaction runs its three bands in turn; the time from one input
//  acceptance to the next is set by the single shift-add multiplier, one
//  multiplier bit per cycle, which runs four products per band
//  reset (rst_n low, synchronous) clears control, configuration registers and the
//  per-entry valid bits of the filter memory at once; no clearing pass is needed
//  a result waiting on out_ready does not block the next input transaction;
//  the sequencer only stalls in its final step while the output register is full
// ----------------------------------------------------------------------------
module three_band_one_pole_lowpass_mixer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tbpl_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tbpl_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [tbpl_pkg::IDX_W-1:0] cfg_index,
  input  logic [tbpl_pkg::CFG_W-1:0] cfg_data
);
  import tbpl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_M1, S_ACC, S_M2, S_Y, S_D, S_M3, S_NS, S_M4, S_V, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [CFG_W-1:0] band_cfg_r [BANDS];
  logic [2:0]       mix_sel_r;

  // latched transaction
  in_t              in_r;
  logic [1:0]       band_r;
  logic             ch_ok_r;

  // filter memory and its valid bits
  logic signed [31:0]    mem [MEM_DEPTH];
  logic signed [31:0]    mem_q_r;
  logic [MEM_DEPTH-1:0]  vld_r;
  logic [ADDR_W-1:0]     addr_w;
  logic                  mem_we;

  // shift-add multiplier
  logic signed [63:0] mul_a_r;
  logic [15:0]        mul_b_r;
  logic [3:0]         mul_cnt_r;
  logic               mul_sgn_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] prod_nxt;

  // per-band working values
  logic signed [31:0] s_r;
  logic signed [31:0] y_r;
  logic signed [39:0] mix_r;
  logic signed [23:0] filt_r [BANDS];

  // current band coefficients
  logic [15:0]        k_w, n_w, g_w;
  logic signed [23:0] x_w;
  logic signed [63:0] acc_w, y_full_w, ns_w, v_w;

  out_t out_r;
  logic out_valid_r;

  assign k_w = band_cfg_r[band_r][47:32];
  assign n_w = band_cfg_r[band_r][31:16];
  assign g_w = band_cfg_r[band_r][15:0];

  always_comb begin
    unique case (band_r)
      2'd0:    x_w = in_r.sample_one;
      2'd1:    x_w = in_r.sample_two;
      default: x_w = in_r.sample_three;
    endcase
  end

  assign addr_w = ADDR_W'(32'(in_r.channel) * BANDS + 32'(band_r));
  assign mem_we = (state_r == S_NS) && ch_ok_r;

  // s << 12 added to k*x
  assign acc_w    = prod_r + (64'(s_r) <<< 12);
  assign y_full_w = round_shift(prod_r, 27);
  assign ns_w     = round_shift(prod_r, 12) + 64'(y_r);
  assign v_w      = round_shift(prod_r, 13);

  // one multiplier bit per cycle; sign bit of a signed operand subtracts
  always_comb begin
    prod_nxt = prod_r;
    if (mul_b_r[0]) begin
      if (mul_sgn_r && mul_cnt_r == 4'd15) prod_nxt = prod_r - mul_a_r;
      else prod_nxt = prod_r + mul_a_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // filter memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_w] <= sat32(ns_w);
    if (state_r == S_RD) mem_q_r <= mem[addr_w];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      mix_sel_r   <= MIX_SELECT_RESET;
      for (int i = 0; i < BANDS; i++) band_cfg_r[i] <= '0;
      band_r      <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BAND_ONE:   band_cfg_r[0] <= cfg_data;
          REG_BAND_TWO:   band_cfg_r[1] <= cfg_data;
          REG_BAND_THREE: band_cfg_r[2] <= cfg_data;
          REG_MIX_SELECT: mix_sel_r     <= cfg_data[2:0];
          default:        mix_sel_r     <= mix_sel_r;
        endcase
      end

      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            ch_ok_r <= 32'(in_data.channel) < CHANNELS;
            band_r  <= 2'd0;
            mix_r   <= 40'(in_data.link_sample);
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_LD;
        S_LD: begin
          s_r       <= (ch_ok_r && vld_r[addr_w]) ? mem_q_r : 32'sd0;
          mul_a_r   <= 64'(x_w);
          mul_b_r   <= k_w;
          mul_sgn_r <= 1'b0;
          mul_cnt_r <= 4'd0;
          prod_r    <= '0;
          state_r   <= S_M1;
        end
        S_M1, S_M2, S_M3, S_M4: begin
          prod_r    <= prod_nxt;
          mul_a_r   <= mul_a_r <<< 1;
          mul_b_r   <= mul_b_r >> 1;
          mul_cnt_r <= mul_cnt_r + 4'd1;
          if (mul_cnt_r == 4'd15) begin
            unique case (state_r)
              S_M1:    state_r <= S_ACC;
              S_M2:    state_r <= S_Y;
              S_M3:    state_r <= S_NS;
              default: state_r <= S_V;
            endcase
          end
        end
        S_ACC: begin
          mul_a_r   <= acc_w;
          mul_b_r   <= n_w;
          mul_sgn_r <= 1'b0;
          mul_cnt_r <= 4'd0;
          prod_r    <= '0;
          state_r   <= S_M2;
        end
        S_Y: begin
          y_r     <= sat32(y_full_w);
          state_r <= S_D;
        end
        S_D: begin
          mul_a_r   <= 64'(x_w) - 64'(y_r);
          mul_b_r   <= k_w;
          mul_sgn_r <= 1'b0;
          mul_cnt_r <= 4'd0;
          prod_r    <= '0;
          state_r   <= S_M3;
        end
        S_NS: begin
          if (ch_ok_r) vld_r[addr_w] <= 1'b1;
          mul_a_r   <= 64'(y_r);
          mul_b_r   <= g_w;
          mul_sgn_r <= 1'b1;
          mul_cnt_r <= 4'd0;
          prod_r    <= '0;
          state_r   <= S_M4;
        end
        S_V: begin
          filt_r[band_r] <= sat24(v_w);
          if (mix_sel_r[band_r]) mix_r <= mix_r + v_w[39:0];
          if (band_r == 2'(BANDS - 1)) begin
            state_r <= S_DONE;
          end else begin
            band_r  <= band_r + 2'd1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.channel_out    <= in_r.channel;
            out_r.filtered_one   <= filt_r[0];
            out_r.filtered_two   <= filt_r[1];
            out_r.filtered_three <= filt_r[2];
            out_r.mix_out        <= sat24(64'(mix_r));
            out_valid_r          <= 1'b1;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/tbpl_checker.sv @@
// ----------------------------------------------------------------------------
// tbpl_checker
// port-level checks on the low-pass mixer, bound to the top level
// ----------------------------------------------------------------------------
module tbpl_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tbpl_pkg::out_t out_data
);
  import tbpl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted transaction keeps the block busy, with in_ready low, before the next input is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too early");

  // a new result appears only at the end of a busy period
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind three_band_one_pole_lowpass_mixer_unit tbpl_checker u_tbpl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
